// File: sv/scp_pkg.sv
package scp_pkg;

  localparam int MAX_COMMANDS = 64;
  localparam int CMD_CNT_W    = $clog2(MAX_COMMANDS + 1);

  localparam logic [7:0] BPP_LIMIT = 8'd32;

  // Field positions of the parser.
  localparam logic [4:0] FP_TYPE     = 5'd0;
  localparam logic [4:0] FP_LEFT     = 5'd2;
  localparam logic [4:0] FP_TOP      = 5'd3;
  localparam logic [4:0] FP_RIGHT    = 5'd4;
  localparam logic [4:0] FP_BOTTOM   = 5'd5;
  localparam logic [4:0] FP_BPP      = 5'd6;
  localparam logic [4:0] FP_FLAGS    = 5'd7;
  localparam logic [4:0] FP_CODEC    = 5'd8;
  localparam logic [4:0] FP_WIDTH    = 5'd9;
  localparam logic [4:0] FP_HEIGHT   = 5'd10;
  localparam logic [4:0] FP_LENGTH   = 5'd11;
  localparam logic [4:0] FP_EXT_HI   = 5'd12;
  localparam logic [4:0] FP_EXT_LO   = 5'd13;
  localparam logic [4:0] FP_EXT_MS   = 5'd14;
  localparam logic [4:0] FP_EXT_S    = 5'd15;
  localparam logic [4:0] FP_PAYLOAD  = 5'd16;
  localparam logic [4:0] FP_ACTION   = 5'd17;
  localparam logic [4:0] FP_FRAME_ID = 5'd18;
  localparam logic [4:0] FP_RESERVED = 5'd19;

  localparam logic [4:0] FID_NONE = 5'd0;
  localparam logic [4:0] FID_TYPE = 5'd1;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_OK    = 3'd1;
  localparam logic [2:0] ST_LIMIT = 3'd2;
  localparam logic [2:0] ST_TYPE  = 3'd3;
  localparam logic [2:0] ST_HDR   = 3'd4;
  localparam logic [2:0] ST_TRUNC = 3'd5;

  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_STREAM_BITS = 2'd1;
  localparam logic [1:0] CFG_FRAME_MARK  = 2'd2;
  localparam logic [1:0] CFG_EXT_MASK    = 2'd3;

  localparam logic [15:0] RST_SET_BITS    = 16'd1;
  localparam logic [15:0] RST_STREAM_BITS = 16'd6;
  localparam logic [15:0] RST_FRAME_MARK  = 16'd4;
  localparam logic [7:0]  RST_EXT_MASK    = 8'd1;

  typedef struct packed {
    logic [15:0] set_bits_code;
    logic [15:0] stream_bits_code;
    logic [15:0] frame_marker_code;
    logic [7:0]  ext_header_mask;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  field_id;
    logic [63:0] field_value;
    logic [6:0]  command_index;
    logic        command_kind;
    logic        command_end;
    logic [2:0]  status;
  } result_t;

  function automatic logic [3:0] field_len(input logic [4:0] pos);
    logic [3:0] len;
    case (pos) inside
      FP_TYPE, FP_LEFT, FP_TOP, FP_RIGHT, FP_BOTTOM, FP_WIDTH, FP_HEIGHT, FP_ACTION:
        len = 4'd2;
      FP_LENGTH, FP_EXT_HI, FP_EXT_LO, FP_FRAME_ID:
        len = 4'd4;
      FP_EXT_MS, FP_EXT_S:
        len = 4'd8;
      default:
        len = 4'd1;
    endcase
    return len;
  endfunction

endpackage

// File: sv/scp_if.sv
interface scp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface scp_result_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_id;
  logic [63:0] field_value;
  logic [6:0]  command_index;
  logic        command_kind;
  logic        command_end;
  logic [2:0]  status;

  modport source (output valid, output field_id, output field_value, output command_index,
                  output command_kind, output command_end, output status, input ready);
  modport sink (input valid, input field_id, input field_value, input command_index,
                input command_kind, input command_end, input status, output ready);
endinterface

// File: sv/scp_cfg_regs.sv
module scp_cfg_regs import scp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_bits_code     <= RST_SET_BITS;
      cfg.stream_bits_code  <= RST_STREAM_BITS;
      cfg.frame_marker_code <= RST_FRAME_MARK;
      cfg.ext_header_mask   <= RST_EXT_MASK;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:    cfg.set_bits_code     <= cfg_data;
        CFG_STREAM_BITS: cfg.stream_bits_code  <= cfg_data;
        CFG_FRAME_MARK:  cfg.frame_marker_code <= cfg_data;
        CFG_EXT_MASK:    cfg.ext_header_mask   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/scp_parser_core.sv
module scp_parser_core import scp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  cfg_t       cfg,
  output result_t    res
);

  logic [4:0]           field_pos, field_pos_next;
  logic [2:0]           byte_pos, byte_pos_next;
  logic [63:0]          assembler, assembler_next;
  logic                 kind_seen, kind_seen_next;
  logic [15:0]          left_seen, left_seen_next;
  logic [15:0]          top_seen, top_seen_next;
  logic [7:0]           flags_seen, flags_seen_next;
  logic [7:0]           bpp_seen, bpp_seen_next;
  logic [15:0]          width_seen, width_seen_next;
  logic                 reserved_bad, reserved_bad_next;
  logic [31:0]          payload_left, payload_left_next;
  logic [CMD_CNT_W-1:0] cmd_count, cmd_count_next;
  logic [2:0]           error_latch, error_latch_next;

  logic [63:0] asm_new;
  logic        field_done;
  logic [2:0]  err;
  logic [4:0]  nxt;
  logic        done;
  logic [31:0] pay_dec;

  assign asm_new    = assembler | (64'(data_byte) << {byte_pos, 3'b000});
  assign field_done = ({1'b0, byte_pos} + 4'd1) >= field_len(field_pos);
  assign pay_dec    = payload_left - 32'd1;

  always_comb begin
    field_pos_next    = field_pos;
    byte_pos_next     = byte_pos;
    assembler_next    = assembler;
    kind_seen_next    = kind_seen;
    left_seen_next    = left_seen;
    top_seen_next     = top_seen;
    flags_seen_next   = flags_seen;
    bpp_seen_next     = bpp_seen;
    width_seen_next   = width_seen;
    reserved_bad_next = reserved_bad;
    payload_left_next = payload_left;
    cmd_count_next    = cmd_count;
    error_latch_next  = error_latch;
    err               = ST_RUN;
    nxt               = FP_TYPE;
    done              = 1'b0;

    res.field_id      = FID_NONE;
    res.field_value   = 64'd0;
    res.command_index = 7'(cmd_count);
    res.command_kind  = 1'b0;
    res.command_end   = 1'b0;
    res.status        = ST_RUN;

    if (error_latch != ST_RUN) begin
      res.status = error_latch;
    end else begin
      if (field_pos == FP_TYPE && byte_pos == 3'd0 &&
          cmd_count >= CMD_CNT_W'(MAX_COMMANDS)) begin
        err = ST_LIMIT;
      end else begin
        res.command_kind = (field_pos == FP_TYPE) ? 1'b0 : kind_seen;
        if (!field_done) begin
          assembler_next = asm_new;
          byte_pos_next  = byte_pos + 3'd1;
        end else begin
          assembler_next  = 64'd0;
          byte_pos_next   = 3'd0;
          res.field_id    = (field_pos == FP_RESERVED) ? FID_NONE :
                            (field_pos == FP_TYPE) ? FID_TYPE : field_pos;
          res.field_value = (field_pos == FP_RESERVED) ? 64'd0 : asm_new;
          case (field_pos)
            FP_TYPE: begin
              if (asm_new[15:0] == cfg.set_bits_code ||
                  asm_new[15:0] == cfg.stream_bits_code) begin
                kind_seen_next = 1'b0;
                nxt = FP_LEFT;
              end else if (asm_new[15:0] == cfg.frame_marker_code) begin
                kind_seen_next = 1'b1;
                nxt = FP_ACTION;
              end else begin
                err = ST_TYPE;
              end
              res.command_kind = (err != ST_RUN) ? 1'b0 : kind_seen_next;
            end
            FP_LEFT: begin
              left_seen_next = asm_new[15:0];
              nxt = FP_TOP;
            end
            FP_TOP: begin
              top_seen_next = asm_new[15:0];
              nxt = FP_RIGHT;
            end
            FP_RIGHT: begin
              if (asm_new[15:0] <= left_seen) reserved_bad_next = 1'b1;
              nxt = FP_BOTTOM;
            end
            FP_BOTTOM: begin
              if (asm_new[15:0] <= top_seen) reserved_bad_next = 1'b1;
              nxt = FP_BPP;
            end
            FP_BPP: begin
              bpp_seen_next = asm_new[7:0];
              nxt = FP_FLAGS;
            end
            FP_FLAGS: begin
              flags_seen_next = asm_new[7:0];
              nxt = FP_RESERVED;
            end
            FP_RESERVED: begin
              if (asm_new[7:0] != 8'd0) reserved_bad_next = 1'b1;
              nxt = FP_CODEC;
            end
            FP_CODEC: nxt = FP_WIDTH;
            FP_WIDTH: begin
              width_seen_next = asm_new[15:0];
              nxt = FP_HEIGHT;
            end
            FP_HEIGHT: begin
              if (asm_new[15:0] == 16'd0) reserved_bad_next = 1'b1;
              nxt = FP_LENGTH;
            end
            FP_LENGTH: begin
              payload_left_next = asm_new[31:0];
              if (reserved_bad || (flags_seen & ~cfg.ext_header_mask) != 8'd0 ||
                  width_seen == 16'd0 || bpp_seen == 8'd0 || bpp_seen > BPP_LIMIT) begin
                err = ST_HDR;
              end else if ((flags_seen & cfg.ext_header_mask) != 8'd0) begin
                nxt = FP_EXT_HI;
              end else if (asm_new[31:0] != 32'd0) begin
                nxt = FP_PAYLOAD;
              end else begin
                done = 1'b1;
              end
            end
            FP_EXT_HI: nxt = FP_EXT_LO;
            FP_EXT_LO: nxt = FP_EXT_MS;
            FP_EXT_MS: nxt = FP_EXT_S;
            FP_EXT_S: begin
              if (payload_left != 32'd0) nxt = FP_PAYLOAD;
              else done = 1'b1;
            end
            FP_PAYLOAD: begin
              payload_left_next = pay_dec;
              if (pay_dec == 32'd0) done = 1'b1;
              else nxt = FP_PAYLOAD;
            end
            FP_ACTION: nxt = FP_FRAME_ID;
            FP_FRAME_ID: done = 1'b1;
            default: nxt = FP_TYPE;
          endcase
          if (err == ST_RUN) begin
            if (done) begin
              res.command_end   = 1'b1;
              cmd_count_next    = cmd_count + CMD_CNT_W'(1);
              field_pos_next    = FP_TYPE;
              reserved_bad_next = 1'b0;
            end else begin
              field_pos_next = nxt;
            end
          end
        end
      end
      if (err != ST_RUN) begin
        res.status        = err;
        error_latch_next  = err;
        res.command_kind  = 1'b0;
        res.command_end   = 1'b0;
      end
      if (last_byte) begin
        if (err == ST_RUN) begin
          res.status = (field_pos_next == FP_TYPE && byte_pos_next == 3'd0) ? ST_OK : ST_TRUNC;
        end
        res.command_index = 7'(cmd_count_next);
      end
    end

    if (last_byte) begin
      field_pos_next    = FP_TYPE;
      byte_pos_next     = 3'd0;
      assembler_next    = 64'd0;
      kind_seen_next    = 1'b0;
      left_seen_next    = 16'd0;
      top_seen_next     = 16'd0;
      flags_seen_next   = 8'd0;
      bpp_seen_next     = 8'd0;
      width_seen_next   = 16'd0;
      reserved_bad_next = 1'b0;
      payload_left_next = 32'd0;
      cmd_count_next    = '0;
      error_latch_next  = ST_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_pos    <= FP_TYPE;
      byte_pos     <= 3'd0;
      assembler    <= 64'd0;
      kind_seen    <= 1'b0;
      left_seen    <= 16'd0;
      top_seen     <= 16'd0;
      flags_seen   <= 8'd0;
      bpp_seen     <= 8'd0;
      width_seen   <= 16'd0;
      reserved_bad <= 1'b0;
      payload_left <= 32'd0;
      cmd_count    <= '0;
      error_latch  <= ST_RUN;
    end else if (fire) begin
      field_pos    <= field_pos_next;
      byte_pos     <= byte_pos_next;
      assembler    <= assembler_next;
      kind_seen    <= kind_seen_next;
      left_seen    <= left_seen_next;
      top_seen     <= top_seen_next;
      flags_seen   <= flags_seen_next;
      bpp_seen     <= bpp_seen_next;
      width_seen   <= width_seen_next;
      reserved_bad <= reserved_bad_next;
      payload_left <= payload_left_next;
      cmd_count    <= cmd_count_next;
      error_latch  <= error_latch_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && last_byte |=> field_pos == FP_TYPE && byte_pos == 3'd0 &&
                          cmd_count == '0 && error_latch == ST_RUN)
    else $error("parse state not cleared after the last beat of a buffer");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    cmd_count <= CMD_CNT_W'(MAX_COMMANDS))
    else $error("command count beyond the limit");

  a_latch_codes: assert property (@(posedge clk) disable iff (rst)
    error_latch == ST_RUN || error_latch == ST_LIMIT ||
    error_latch == ST_TYPE || error_latch == ST_HDR)
    else $error("latched error is not a parse error code");

  a_quiet_after_error: assert property (@(posedge clk) disable iff (rst)
    error_latch != ST_RUN |-> res.field_id == FID_NONE && !res.command_end &&
                              res.status == error_latch)
    else $error("field reported while an error is latched");

endmodule

// File: sv/scp_out_reg.sv
module scp_out_reg import scp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  result_t          res,
  output logic             hold_free,
  scp_result_if.source     out_bus
);

  logic    out_valid;
  result_t out_data;

  assign hold_free = !out_valid || out_bus.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hold_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_free && load) begin
      out_data <= res;
    end
  end

  assign out_bus.valid         = out_valid;
  assign out_bus.field_id      = out_data.field_id;
  assign out_bus.field_value   = out_data.field_value;
  assign out_bus.command_index = out_data.command_index;
  assign out_bus.command_kind  = out_data.command_kind;
  assign out_bus.command_end   = out_data.command_end;
  assign out_bus.status        = out_data.status;

endmodule

// File: sv/surface_command_parser.sv
// A result beat appears on the output channel in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the output stalls; the single output register
// takes a new result whenever it is empty or its current beat is taken in the same cycle.
// Reset (rst, synchronous, active high) clears the parse state, the command count,
// the error latch and the output valid, and loads the type codes and flag mask defaults.
module surface_command_parser import scp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  scp_byte_if.sink    in_bus,
  scp_result_if.source out_bus
);

  cfg_t    cfg;
  result_t res;
  logic    hold_free;
  logic    fire;

  assign in_bus.ready = hold_free;
  assign fire         = in_bus.valid && hold_free;

  scp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scp_parser_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (in_bus.data_byte),
    .last_byte (in_bus.last_byte),
    .cfg       (cfg),
    .res       (res)
  );

  scp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (res),
    .hold_free (hold_free),
    .out_bus   (out_bus)
  );

endmodule
